>>> sv/ctf_pkg.sv
// shared types and constants for the complementary tilt filter
// no dependencies
package ctf_pkg;

   localparam int ANG_W   = 25;
   localparam int RAW_W   = 16;
   localparam int CORD_W  = 28; // 16b operand scaled by 256, plus cordic growth
   localparam int ATAN_N  = 24;
   localparam logic signed [ANG_W-1:0] ANG_MAX = 25'sh0FFFFFF;
   localparam logic signed [ANG_W-1:0] ANG_MIN = -25'sh1000000;
   localparam logic signed [ANG_W-1:0] DEG180  = 25'sd11796480;

   localparam logic [2:0] REG_GOFS_X = 3'd0;
   localparam logic [2:0] REG_GOFS_Y = 3'd1;
   localparam logic [2:0] REG_PERIOD = 3'd2;
   localparam logic [2:0] REG_ALPHA  = 3'd3;
   localparam logic [2:0] REG_PTRIM  = 3'd4;
   localparam logic [2:0] REG_RTRIM  = 3'd5;

   typedef struct packed {
      logic signed [RAW_W-1:0] ax;
      logic signed [RAW_W-1:0] ay;
      logic signed [RAW_W-1:0] az;
      logic signed [RAW_W:0]   gx;
      logic signed [RAW_W:0]   gy;
   } sample_type;

   function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [4:0] i);
      logic signed [ANG_W-1:0] r;
      case (i)
         5'd0:  r = 25'sd2949120;
         5'd1:  r = 25'sd1740967;
         5'd2:  r = 25'sd919879;
         5'd3:  r = 25'sd466945;
         5'd4:  r = 25'sd234379;
         5'd5:  r = 25'sd117304;
         5'd6:  r = 25'sd58666;
         5'd7:  r = 25'sd29335;
         5'd8:  r = 25'sd14668;
         5'd9:  r = 25'sd7334;
         5'd10: r = 25'sd3667;
         5'd11: r = 25'sd1833;
         5'd12: r = 25'sd917;
         5'd13: r = 25'sd458;
         5'd14: r = 25'sd229;
         5'd15: r = 25'sd115;
         5'd16: r = 25'sd57;
         5'd17: r = 25'sd29;
         5'd18: r = 25'sd14;
         5'd19: r = 25'sd7;
         5'd20: r = 25'sd4;
         5'd21: r = 25'sd2;
         5'd22: r = 25'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [47:0] v);
      if (v > 48'(ANG_MAX)) return ANG_MAX;
      if (v < 48'(ANG_MIN)) return ANG_MIN;
      return v[ANG_W-1:0];
   endfunction

endpackage

>>> sv/ctf_front.sv
// front end: takes samples, applies gyro offsets, queues them for the back end
// depends on ctf_pkg
module ctf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [79:0]          req_tdata,
   input  logic signed [15:0]   gofs_x,
   input  logic signed [15:0]   gofs_y,
   output logic                 q_valid,
   input  logic                 q_pop,
   output ctf_pkg::sample_type  q_data
);
   import ctf_pkg::*;

   // two-entry queue
   sample_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   sample_type s;
   logic       push;

   always_comb begin
      s.ax = req_tdata[15:0];
      s.ay = req_tdata[31:16];
      s.az = req_tdata[47:32];
      s.gx = 17'(signed'(req_tdata[63:48])) + 17'(gofs_x);
      s.gy = 17'(signed'(req_tdata[79:64])) + 17'(gofs_y);
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push   = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rp_ff];
   assign wp_in  = wp_ff ^ push;
   assign rp_in  = rp_ff ^ (q_pop && q_valid);
   assign cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= s;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !q_pop) |=> cnt_ff == 2'd2)
      else $error("queue lost an entry");
   assert property (@(posedge clock) disable iff (reset)
      (push && !(q_pop && q_valid)) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("push not counted");
endmodule

>>> sv/ctf_cordic.sv
// iterative cordic atan2, one rotation per cycle
// depends on ctf_pkg
module ctf_cordic #(
   parameter int STEPS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [15:0]          y_in,
   input  logic signed [15:0]          x_in,
   output logic                        done,
   output logic signed [ctf_pkg::ANG_W-1:0] angle
);
   import ctf_pkg::*;

   localparam int N = (STEPS < ATAN_N) ? STEPS : ATAN_N;

   logic signed [CORD_W-1:0] x_ff, y_ff, x_in_s, y_in_s;
   logic signed [ANG_W-1:0]  z_ff, z_in;
   logic [4:0]               i_ff, i_in;
   logic                     busy_ff, busy_in, done_ff, done_in;
   logic signed [CORD_W-1:0] xs, ys, xi, yi;

   always_comb begin
      xi = CORD_W'(x_in) <<< 8;
      yi = CORD_W'(y_in) <<< 8;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      x_in_s = x_ff; y_in_s = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         i_in = '0;
         if (x_in == 0 && y_in == 0) begin
            x_in_s = '0; y_in_s = '0; z_in = '0;
            busy_in = 1'b0; done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            if (x_in < 0) begin
               x_in_s = -xi; y_in_s = -yi;
               z_in = (y_in >= 0) ? DEG180 : -DEG180;
            end else begin
               x_in_s = xi; y_in_s = yi; z_in = '0;
            end
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in_s = x_ff + ys; y_in_s = y_ff - xs; z_in = z_ff + atan_lookup(i_ff);
         end else begin
            x_in_s = x_ff - ys; y_in_s = y_ff + xs; z_in = z_ff - atan_lookup(i_ff);
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(N - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in_s; y_ff <= y_in_s; z_ff <= z_in; i_ff <= i_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("cordic done while busy");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> i_ff < 5'(N))
      else $error("cordic step out of range");
   assert property (@(posedge clock) disable iff (reset) $fell(busy_ff) |-> done_ff)
      else $error("cordic ended without done");
endmodule

>>> sv/ctf_back.sv
// back end: gyro integration, two cordic passes, blend and trim
// depends on ctf_pkg and ctf_cordic
module ctf_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_pop,
   input  ctf_pkg::sample_type        q_data,
   input  logic [15:0]                period,
   input  logic [15:0]                alpha,
   input  logic signed [24:0]         ptrim,
   input  logic signed [24:0]         rtrim,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [55:0]                rsp_tdata
);
   import ctf_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MULG  = 10'b0000000010,
      S_DIVG  = 10'b0000000100,
      S_INTG  = 10'b0000001000,
      S_CP    = 10'b0000010000,
      S_CR    = 10'b0000100000,
      S_BM    = 10'b0001000000,
      S_BS    = 10'b0010000000,
      S_TRIM  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type st_ff, st_in;
   sample_type smp_ff;
   logic signed [ANG_W-1:0] pest_ff, rest_ff, pest_in, rest_in;
   logic signed [ANG_W-1:0] tp_ff, tr_ff;
   logic [32:0] mx_ff, my_ff;        // magnitudes of gyro*period
   logic        nx_ff, ny_ff;
   logic [23:0] qx_ff, qy_ff;        // rounded quotients
   logic signed [47:0] bp_ff, br_ff, bp2_ff, br2_ff;
   logic [55:0] out_ff;
   logic        ov_ff;

   logic        c_start, c_done;
   logic signed [15:0] c_y;
   logic signed [ANG_W-1:0] c_ang;

   ctf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(c_start),
      .y_in(c_y), .x_in(smp_ff.az), .done(c_done), .angle(c_ang)
   );

   // divide by 1000 via reciprocal: q = (m*2^k/1000) >> k, then one correction
   localparam logic [23:0] RECIP = 24'd8589935; // ceil(2^33/1000)
   function automatic logic [23:0] div1000(input logic [32:0] m);
      logic [56:0] p;
      logic [23:0] q;
      p = 57'(m) * 57'(RECIP);
      q = p[56:33];
      if (34'(m) < 34'(q) * 34'd1000) q = q - 24'd1;
      return q;
   endfunction

   logic signed [33:0] px, py;
   logic signed [47:0] sp, sr;
   logic [16:0] beta;

   always_comb begin
      px = 34'(smp_ff.gx) * 34'(signed'({1'b0, period}));
      py = 34'(smp_ff.gy) * 34'(signed'({1'b0, period}));
      beta = 17'd65536 - 17'(alpha);
      sp = bp_ff + bp2_ff + 48'sd32768;
      sr = br_ff + br2_ff + 48'sd32768;
      st_in = st_ff;
      pest_in = pest_ff; rest_in = rest_ff;
      c_start = 1'b0; c_y = smp_ff.ax;
      case (st_ff)
         S_IDLE: if (q_valid) st_in = S_MULG;
         S_MULG: st_in = S_DIVG;
         S_DIVG: st_in = S_INTG;
         S_INTG: begin
            rest_in = sat_ang(48'(rest_ff) + (nx_ff ? -48'(qx_ff) : 48'(qx_ff)));
            pest_in = sat_ang(48'(pest_ff) - (ny_ff ? -48'(qy_ff) : 48'(qy_ff)));
            c_start = 1'b1; c_y = smp_ff.ax;
            st_in = S_CP;
         end
         S_CP: if (c_done) begin
            c_start = 1'b1; c_y = smp_ff.ay;
            st_in = S_CR;
         end
         S_CR: if (c_done) st_in = S_BM;
         S_BM: st_in = S_BS;
         S_BS: begin
            pest_in = sat_ang(sp >>> 16);
            rest_in = sat_ang(sr >>> 16);
            st_in = S_TRIM;
         end
         S_TRIM: if (!ov_ff) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   assign q_pop = (st_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         pest_ff <= '0;
         rest_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         pest_ff <= pest_in;
         rest_ff <= rest_in;
         if (st_ff == S_TRIM && !ov_ff) ov_ff <= 1'b1;
         else if (ov_ff && rsp_tready) ov_ff <= 1'b0;
      end
      if (q_pop) smp_ff <= q_data;
      if (st_ff == S_MULG) begin
         nx_ff <= px < 0; mx_ff <= 33'(px < 0 ? -px : px);
         ny_ff <= py < 0; my_ff <= 33'(py < 0 ? -py : py);
      end
      if (st_ff == S_DIVG) begin
         qx_ff <= div1000(mx_ff + 33'd500);
         qy_ff <= div1000(my_ff + 33'd500);
      end
      if (st_ff == S_CP && c_done) tp_ff <= c_ang;
      if (st_ff == S_CR && c_done) tr_ff <= c_ang;
      if (st_ff == S_BM) begin
         bp_ff  <= 48'(pest_ff) * 48'(signed'({1'b0, alpha}));
         br_ff  <= 48'(rest_ff) * 48'(signed'({1'b0, alpha}));
         bp2_ff <= 48'(tp_ff) * 48'(signed'({1'b0, beta}));
         br2_ff <= 48'(tr_ff) * 48'(signed'({1'b0, beta}));
      end
      if (st_ff == S_TRIM && !ov_ff) begin
         out_ff <= {6'b0, sat_ang(48'(rest_ff) + 48'(rtrim)),
                          sat_ang(48'(pest_ff) + 48'(ptrim))};
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while waiting");
   assert property (@(posedge clock) disable iff (reset) (st_ff == S_TRIM) |-> !(q_pop))
      else $error("pop during trim");
   assert property (@(posedge clock) disable iff (reset) (ov_ff && !rsp_tready) |=> ov_ff)
      else $error("result dropped");
endmodule

>>> sv/complementary_tilt_filter.sv
// Complementary pitch/roll filter. One IMU sample per transfer; each yields one
// result transfer. The time per item is mostly set by two back-to-back passes of one
// shared iterative cordic unit in the back end (a pass whose accelerometer pair
// is zero skips the rotations instead).
// A two-entry queue in the front end accepts further samples meanwhile.
module complementary_tilt_filter #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // pitch_angle, roll_angle, zero fill
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   import ctf_pkg::*;

   logic signed [15:0] gofs_x_ff, gofs_y_ff;
   logic [15:0] period_ff, alpha_ff;
   logic signed [24:0] ptrim_ff, rtrim_ff;
   logic q_valid, q_pop;
   sample_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         gofs_x_ff <= '0; gofs_y_ff <= '0;
         period_ff <= 16'd10000; alpha_ff <= 16'd64225;
         ptrim_ff <= '0; rtrim_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_GOFS_X: gofs_x_ff <= csr_wdata[15:0];
            REG_GOFS_Y: gofs_y_ff <= csr_wdata[15:0];
            REG_PERIOD: period_ff <= csr_wdata[15:0];
            REG_ALPHA:  alpha_ff  <= csr_wdata[15:0];
            REG_PTRIM:  ptrim_ff  <= csr_wdata;
            REG_RTRIM:  rtrim_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   ctf_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .gofs_x(gofs_x_ff), .gofs_y(gofs_y_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
   );

   ctf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
      .period(period_ff), .alpha(alpha_ff), .ptrim(ptrim_ff), .rtrim(rtrim_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule
